FILE: hw/rtl/orthographic_projection_defines.svh
// assertion helpers for the orthographic projection block
`ifndef ORTHOGRAPHIC_PROJECTION_DEFINES_SVH
`define ORTHOGRAPHIC_PROJECTION_DEFINES_SVH

// implication checked on every rising edge outside reset
`define OP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define OP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/orthoproj_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package orthoproj_pkg;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STAGES   = 20;
    localparam int NSTG  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int LAT_W = 24;
    localparam int LON_W = 25;
    localparam int SCL_W = 20;
    localparam int OUT_W = 22;
    localparam int CW    = 34;   // cordic x/y width, Q30 with headroom
    localparam int AW    = 34;   // cordic angle width, binary turns
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [1:0] REG_CLAT  = 2'd0;
    localparam logic [1:0] REG_CLON  = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;
    localparam logic [1:0] REG_FLIP  = 2'd3;

    localparam int LAT_LAT = 2;              // pre stages: delta, turn conversion
    localparam int MUL_LAT = 4;              // product stages after cordic
    localparam int LATENCY = LAT_LAT + NSTG + MUL_LAT;

    typedef struct packed {
        logic signed [AW-1:0] a;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 neg;
    } cordic_t;

    typedef struct packed {
        cordic_t c_clat;
        cordic_t c_lat;
        cordic_t c_dlon;
    } lane_t;

    function automatic logic signed [AW-1:0] atan_turn(input int i);
        logic signed [AW-1:0] r;
        case (i)
            0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
            3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
            6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
            9: r = 34'sd1335087;   10: r = 34'sd667544;    11: r = 34'sd333772;
            12: r = 34'sd166886;   13: r = 34'sd83443;     14: r = 34'sd41722;
            15: r = 34'sd20861;    16: r = 34'sd10430;     17: r = 34'sd5215;
            18: r = 34'sd2608;     19: r = 34'sd1304;      20: r = 34'sd652;
            21: r = 34'sd326;      22: r = 34'sd163;       23: r = 34'sd81;
            24: r = 34'sd41;       25: r = 34'sd20;        26: r = 34'sd10;
            27: r = 34'sd5;        28: r = 34'sd3;         29: r = 34'sd1;
            30: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // 32-bit binary turn to cordic start state with quadrant fold
    function automatic cordic_t cordic_init(input logic [31:0] t);
        cordic_t c;
        logic signed [AW-1:0] a;
        a = AW'(signed'(t));
        c.neg = 1'b0;
        if (a > (AW'(1) <<< 30)) begin
            a = a - (AW'(1) <<< 31);
            c.neg = 1'b1;
        end else if (a < -(AW'(1) <<< 30)) begin
            a = a + (AW'(1) <<< 31);
            c.neg = 1'b1;
        end
        c.a = a;
        c.x = GAIN_Q30;
        c.y = '0;
        return c;
    endfunction

    function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
                                                      input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return CW'(p >>> 30);
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/orthoproj_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one cordic rotation step for the three angles of an item
module orthoproj_cell (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [4:0]           stage,
    input  wire orthoproj_pkg::lane_t d_in,
    output orthoproj_pkg::lane_t      d_out
);
    orthoproj_pkg::lane_t q_reg, q_next;

    function automatic orthoproj_pkg::cordic_t step(input orthoproj_pkg::cordic_t c,
                                                    input logic [4:0] s);
        orthoproj_pkg::cordic_t r;
        logic signed [orthoproj_pkg::CW-1:0] xs, ys;
        xs = c.x >>> s;
        ys = c.y >>> s;
        r = c;
        if (!c.a[orthoproj_pkg::AW-1]) begin
            r.x = c.x - ys;
            r.y = c.y + xs;
            r.a = c.a - orthoproj_pkg::atan_turn(int'(s));
        end else begin
            r.x = c.x + ys;
            r.y = c.y - xs;
            r.a = c.a + orthoproj_pkg::atan_turn(int'(s));
        end
        return r;
    endfunction

    always_comb begin
        q_next.c_clat = step(d_in.c_clat, stage);
        q_next.c_lat  = step(d_in.c_lat, stage);
        q_next.c_dlon = step(d_in.c_dlon, stage);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/orthographic_projection.sv
`timescale 1ns / 1ps
`default_nettype none
// orthographic map projection, one point per item
// s_axis: tdata = latitude (24b signed Q.16) then longitude (25b signed Q.16)
// m_axis: tdata = x_coord (22b) then y_coord (22b); tuser = visible
// config: cfg_we/cfg_addr/cfg_wdata, 0 center_lat, 1 center_lon, 2 scale,
//   3 flip_x; write only while idle
// the datapath is a pipeline of CORDIC_STAGES rotation cells plus two
// angle-prep stages and four product stages
// throughput is one item per cycle unless stalled; the whole pipe advances together
// when the output register is free or empty, so a stalled receiver holds
// every stage in place and s_axis_tready falls with it
// reset clears the valid bits of all stages and restores the registers
// to center 0/0, scale one, no flip
module orthographic_projection (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // latitude[23:0], longitude[48:24]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // x_coord[21:0], y_coord[43:22]
    output logic             m_axis_tuser,   // visible
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [24:0] cfg_wdata
);
    localparam int NS = orthoproj_pkg::NSTG;
    localparam int CW = orthoproj_pkg::CW;
    localparam int L  = orthoproj_pkg::LATENCY;

    logic signed [23:0] clat_reg;
    logic signed [24:0] clon_reg;
    logic [19:0]        scale_reg;
    logic               flip_reg;
    logic [L-1:0]       vld_reg;
    logic               adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clat_reg  <= '0;
            clon_reg  <= '0;
            scale_reg <= 20'd65536;
            flip_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                orthoproj_pkg::REG_CLAT:  clat_reg  <= cfg_wdata[23:0];
                orthoproj_pkg::REG_CLON:  clon_reg  <= cfg_wdata;
                orthoproj_pkg::REG_SCALE: scale_reg <= cfg_wdata[19:0];
                orthoproj_pkg::REG_FLIP:  flip_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[L-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = vld_reg[L-1];

    // stage 0: reduce angles modulo 360 degrees
    localparam logic signed [27:0] D360 = 28'sd45 <<< (orthoproj_pkg::ANGLE_FRAC_BITS + 3);
    logic [27:0] r_clat_reg, r_lat_reg, r_dl_reg;

    function automatic logic [27:0] mod360(input logic signed [27:0] v);
        logic signed [27:0] r;
        r = v;
        // |v| < 2*360 deg here, so one or two fixes suffice
        if (r < 0) r = r + D360;
        if (r < 0) r = r + D360;
        if (r >= D360) r = r - D360;
        if (r >= D360) r = r - D360;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_clat_reg <= mod360(28'(clat_reg));
            r_lat_reg  <= mod360(28'(signed'(s_axis_tdata[23:0])));
            r_dl_reg   <= mod360(28'(signed'(s_axis_tdata[48:24])) - 28'(clon_reg));
        end
    end

    // stage 1: scale to binary turns, divide by 45 via reciprocal
    function automatic logic [31:0] to_turn(input logic [27:0] r);
        logic [47:0] n;
        logic [47:0] q;
        logic [47:0] rem;
        n   = (48'(r) << (29 - orthoproj_pkg::ANGLE_FRAC_BITS)) + 48'd22;
        q   = 48'((72'(n) * 72'd1527099483) >> 36);
        rem = n - q * 48'd45;
        if (rem >= 48'd45) q = q + 48'd1;
        return q[31:0];
    endfunction

    orthoproj_pkg::lane_t chain [0:NS];
    always_ff @(posedge aclk) begin
        if (adv) begin
            chain[0].c_clat <= orthoproj_pkg::cordic_init(to_turn(r_clat_reg));
            chain[0].c_lat  <= orthoproj_pkg::cordic_init(to_turn(r_lat_reg));
            chain[0].c_dlon <= orthoproj_pkg::cordic_init(to_turn(r_dl_reg));
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_cell
        orthoproj_cell u_cell (
            .aclk  (aclk),
            .en    (adv),
            .stage (5'(g)),
            .d_in  (chain[g]),
            .d_out (chain[g+1])
        );
    end

    // unfold quadrants
    orthoproj_pkg::lane_t lz;
    assign lz = chain[NS];
    logic signed [CW-1:0] sp, cp, sl, cl, sd, cd;
    assign sp = lz.c_clat.neg ? -lz.c_clat.y : lz.c_clat.y;
    assign cp = lz.c_clat.neg ? -lz.c_clat.x : lz.c_clat.x;
    assign sl = lz.c_lat.neg  ? -lz.c_lat.y  : lz.c_lat.y;
    assign cl = lz.c_lat.neg  ? -lz.c_lat.x  : lz.c_lat.x;
    assign sd = lz.c_dlon.neg ? -lz.c_dlon.y : lz.c_dlon.y;
    assign cd = lz.c_dlon.neg ? -lz.c_dlon.x : lz.c_dlon.x;

    // m1: first-level products
    logic signed [CW-1:0] clcd_reg, spsl_reg, cpsl_reg, u_reg, cp1_reg, sp1_reg;
    logic [19:0] scl1_reg, scl2_reg;
    logic        flp1_reg, flp2_reg, flp3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            clcd_reg <= orthoproj_pkg::mul_q30(cl, cd);
            spsl_reg <= orthoproj_pkg::mul_q30(sp, sl);
            cpsl_reg <= orthoproj_pkg::mul_q30(cp, sl);
            u_reg    <= orthoproj_pkg::mul_q30(cl, sd);
            cp1_reg  <= cp;
            sp1_reg  <= sp;
            scl1_reg <= scale_reg;
            flp1_reg <= flip_reg;
        end
    end

    // m2: z and v
    logic signed [CW-1:0] z_reg, v_reg, u2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            z_reg    <= spsl_reg + orthoproj_pkg::mul_q30(cp1_reg, clcd_reg);
            v_reg    <= cpsl_reg - orthoproj_pkg::mul_q30(sp1_reg, clcd_reg);
            u2_reg   <= u_reg;
            scl2_reg <= scl1_reg;
            flp2_reg <= flp1_reg;
        end
    end

    // m3: scale products, Q46
    logic signed [55:0] tu_reg, tv_reg;
    logic               vis3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            tu_reg   <= 56'(u2_reg) * 56'(signed'({1'b0, scl2_reg}));
            tv_reg   <= 56'(v_reg) * 56'(signed'({1'b0, scl2_reg}));
            vis3_reg <= !z_reg[CW-1];
            flp3_reg <= flp2_reg;
        end
    end

    function automatic logic [21:0] to_plot(input logic signed [55:0] t, input logic plus);
        logic signed [55:0] v;
        v = plus ? (56'sd1 <<< 46) + t : (56'sd1 <<< 46) - t;
        v = (v + (56'sd1 <<< 30)) >>> 31;
        if (v > 56'sd2097151) v = 56'sd2097151;
        if (v < -56'sd2097152) v = -56'sd2097152;
        return v[21:0];
    endfunction

    // m4: output register
    logic [47:0] od_reg;
    logic        ovis_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            ovis_reg <= vis3_reg;
            od_reg   <= vis3_reg ? {4'd0, to_plot(tv_reg, 1'b0), to_plot(tu_reg, !flp3_reg)}
                                 : '0;
        end
    end
    assign m_axis_tdata = od_reg;
    assign m_axis_tuser = ovis_reg;

    `include "orthographic_projection_defines.svh"
    `OP_ASSERT_IMP(a_hidden_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 48'd0, "hidden item not zero")
    `OP_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")
    `OP_ASSERT_IMP(a_ready_adv, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "ready while stalled")
endmodule
`default_nettype wire
